/* rtl/core/assert_macros.svh */
// Assertion macros for the label confusion histogram RTL.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define LCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LCH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/lch_pkg.sv */
// Package for the label confusion histogram: item types, codes and helpers.
// No dependencies.
`default_nettype none

package lch_pkg;

  typedef enum logic [2:0] {
    OP_PAIR     = 3'd0,
    OP_END      = 3'd1,
    OP_RD_TOTAL = 3'd2,
    OP_RD_MISM  = 3'd3,
    OP_RD_CONF  = 3'd4,
    OP_RD_GRAND = 3'd5
  } op_e;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT_TOTALS     = 2'd0,
    CFG_COUNT_MISMATCHES = 2'd1,
    CFG_COUNT_CONFUSION  = 2'd2
  } cfg_idx_e;

  localparam int NUM_STORES = 4;
  localparam int ST_TOTAL   = 0;
  localparam int ST_MISM_A  = 1;
  localparam int ST_MISM_B  = 2;
  localparam int ST_CONF    = 3;

  localparam logic [47:0] GRAND_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] ENTRY_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] label_a;
    logic [7:0] label_b;
  } in_item_t;

  typedef struct packed {
    logic [47:0] frames;
    logic [47:0] mismatches;
    logic [31:0] entry_value;
    logic        is_mismatch;
  } out_item_t;

  // Write enables of the four stores; bit order follows the ST_* indices.
  typedef struct packed {
    logic conf;
    logic mism_b;
    logic mism_a;
    logic total;
  } wr_en_t;

  function automatic logic [31:0] clip_entry(input logic [63:0] v);
    return (|v[63:32]) ? ENTRY_MAX : v[31:0];
  endfunction

  function automatic logic [47:0] clip_grand(input logic [63:0] v);
    return (|v[63:48]) ? GRAND_MAX : v[47:0];
  endfunction

  function automatic logic [47:0] sat_add_grand(input logic [47:0] g, input logic [63:0] s);
    logic [64:0] sum;
    sum = {17'b0, g} + {1'b0, s};
    return (sum > {17'b0, GRAND_MAX}) ? GRAND_MAX : sum[47:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lch_in_if.sv */
// Input channel of the label confusion histogram: valid, ready, one item.
// Depends on lch_pkg.
`default_nettype none

interface lch_in_if;
  logic             valid;
  logic             ready;
  lch_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

/* rtl/core/lch_out_if.sv */
// Result channel of the label confusion histogram: valid, ready, one item.
// Depends on lch_pkg.
`default_nettype none

interface lch_out_if;
  logic              valid;
  logic              ready;
  lch_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

/* rtl/core/lch_ram.sv */
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module lch_ram #(
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/lch_store.sv */
// Histogram and confusion stores with last-write forwarding and clear sweep.
// Depends on lch_pkg, lch_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lch_store #(
  parameter int IDX_W       = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  output logic                                         busy_o,
  input  logic                                         rd_en_i,
  input  logic [IDX_W-1:0]                             rd_a_i,
  input  logic [IDX_W-1:0]                             rd_b_i,
  output logic [lch_pkg::NUM_STORES-1:0][COUNT_WIDTH-1:0] rd_data_o,
  input  lch_pkg::wr_en_t                              wr_en_i,
  input  logic [IDX_W-1:0]                             wr_a_i,
  input  logic [IDX_W-1:0]                             wr_b_i,
  input  logic [lch_pkg::NUM_STORES-1:0][COUNT_WIDTH-1:0] wr_data_i
);

  localparam int CONF_W = 2 * IDX_W;

  logic                                          busy_q;
  logic [CONF_W-1:0]                             clr_cnt_q;
  logic [lch_pkg::NUM_STORES-1:0]                wr_en_v;
  logic [lch_pkg::NUM_STORES-1:0][CONF_W-1:0]    rd_addr;
  logic [lch_pkg::NUM_STORES-1:0][CONF_W-1:0]    wr_addr;
  logic [lch_pkg::NUM_STORES-1:0][CONF_W-1:0]    rd_addr_q;
  logic [lch_pkg::NUM_STORES-1:0]                lw_vld_q;
  logic [lch_pkg::NUM_STORES-1:0][CONF_W-1:0]    lw_addr_q;
  logic [lch_pkg::NUM_STORES-1:0][COUNT_WIDTH-1:0] lw_data_q;
  logic [lch_pkg::NUM_STORES-1:0][COUNT_WIDTH-1:0] ram_rdata;

  assign wr_en_v = wr_en_i;
  assign busy_o  = busy_q;

  always_comb begin
    rd_addr[lch_pkg::ST_TOTAL]  = CONF_W'(rd_a_i);
    rd_addr[lch_pkg::ST_MISM_A] = CONF_W'(rd_a_i);
    rd_addr[lch_pkg::ST_MISM_B] = CONF_W'(rd_b_i);
    rd_addr[lch_pkg::ST_CONF]   = {rd_a_i, rd_b_i};
    wr_addr[lch_pkg::ST_TOTAL]  = CONF_W'(wr_a_i);
    wr_addr[lch_pkg::ST_MISM_A] = CONF_W'(wr_a_i);
    wr_addr[lch_pkg::ST_MISM_B] = CONF_W'(wr_b_i);
    wr_addr[lch_pkg::ST_CONF]   = {wr_a_i, wr_b_i};
  end

  // Clear sweep: zero every entry after reset, one address per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      clr_cnt_q <= clr_cnt_q + CONF_W'(1);
      if (clr_cnt_q == {CONF_W{1'b1}}) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_vld_q <= '0;
    end else if (!busy_q) begin
      lw_vld_q <= lw_vld_q | wr_en_v;
    end
  end

  for (genvar k = 0; k < lch_pkg::NUM_STORES; k++) begin : g_store
    localparam int AW = (k == lch_pkg::ST_CONF) ? CONF_W : IDX_W;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;

    assign ram_we    = busy_q | wr_en_v[k];
    assign ram_waddr = busy_q ? clr_cnt_q[AW-1:0] : wr_addr[k][AW-1:0];
    assign ram_wdata = busy_q ? '0 : wr_data_i[k];

    lch_ram #(
      .WIDTH  (COUNT_WIDTH),
      .ADDR_W (AW)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (ram_waddr),
      .wdata_i (ram_wdata),
      .re_i    (rd_en_i),
      .raddr_i (rd_addr[k][AW-1:0]),
      .rdata_o (ram_rdata[k])
    );

    always_ff @(posedge clk_i) begin
      if (rd_en_i) begin
        rd_addr_q[k] <= rd_addr[k];
      end
      if (wr_en_v[k] && !busy_q) begin
        lw_addr_q[k] <= wr_addr[k];
        lw_data_q[k] <= wr_data_i[k];
      end
    end

    // Forward the last write when the read raced it to the same entry.
    assign rd_data_o[k] = (lw_vld_q[k] && (lw_addr_q[k] == rd_addr_q[k])) ?
                          lw_data_q[k] : ram_rdata[k];
  end

  `LCH_ASSERT(a_no_write_in_clear, busy_q |-> (wr_en_v == '0), "item write during clear sweep")
  `LCH_ASSERT(a_no_read_in_clear, rd_en_i |-> !busy_q, "item read during clear sweep")
  `LCH_ASSERT(a_sweep_advances, (busy_q && clr_cnt_q != {CONF_W{1'b1}}) |=> (busy_q && clr_cnt_q == $past(clr_cnt_q) + CONF_W'(1)), "clear sweep stalled or ended early")

endmodule

`default_nettype wire

/* rtl/core/label_confusion_histogram_core.sv */
// Top level of the label confusion histogram: pipeline control, counters, output register.
// Depends on lch_pkg, lch_in_if, lch_out_if, lch_store and assert_macros.svh.
//
//   channel  dir  handshake       payload
//   in_i     in   valid / ready   operation, label_a, label_b
//   out_o    out  valid / ready   frames, mismatches, entry_value, is_mismatch
//   cfg      in   cfg_we_i        cfg_idx_i, cfg_data_i
//
// One transaction per cycle when not stalled; results pass the stage 1 register and then the output register.
// Stage 0 reads the stores, stage 1 increments and writes back, forwarding the
// previous write when the same entry was read in the same cycle.
// After reset the clear sweep zeroes all (2**clog2(NUM_LABELS))**2 confusion entries
// (65536 at 256 labels); no input is taken until it ends.
// A stalled output holds stage 1 and, through it, the input.
`default_nettype none
`include "assert_macros.svh"

module label_confusion_histogram_core #(
  parameter int NUM_LABELS  = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lch_in_if.sink                           in_i,
  lch_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [lch_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lch_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int IDX_W = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;

  logic en_totals_q;
  logic en_mism_q;
  logic en_conf_q;

  logic                   busy;
  logic                   accept;
  logic                   s1_adv;
  logic                   s1_vld_q;
  logic [2:0]             s1_op_q;
  logic [IDX_W-1:0]       s1_a_q;
  logic [IDX_W-1:0]       s1_b_q;
  logic                   s1_a_ok_q;
  logic                   s1_b_ok_q;
  logic                   s1_diff_q;
  logic                   in_a_ok;
  logic                   in_b_ok;
  logic [IDX_W-1:0]       rd_b;

  logic [lch_pkg::NUM_STORES-1:0][COUNT_WIDTH-1:0] rd_data;
  logic [lch_pkg::NUM_STORES-1:0][COUNT_WIDTH-1:0] wr_data;
  lch_pkg::wr_en_t        wr_en_c;
  lch_pkg::wr_en_t        wr_en;

  logic [COUNT_WIDTH-1:0] seq_frames_q, seq_frames_d;
  logic [COUNT_WIDTH-1:0] seq_mism_q, seq_mism_d;
  logic [47:0]            grand_frames_q, grand_frames_d;
  logic [47:0]            grand_mism_q, grand_mism_d;
  logic [COUNT_WIDTH:0]   mism_sum;
  logic [COUNT_WIDTH-1:0] mism_sat;

  logic                   res_vld;
  lch_pkg::out_item_t     res_item;
  logic                   out_vld_q;
  lch_pkg::out_item_t     out_item_q;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == {COUNT_WIDTH{1'b1}}) ? v : v + COUNT_WIDTH'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_totals_q <= 1'b0;
      en_mism_q   <= 1'b0;
      en_conf_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lch_pkg::CFG_COUNT_TOTALS:     en_totals_q <= cfg_data_i[0];
        lch_pkg::CFG_COUNT_MISMATCHES: en_mism_q   <= cfg_data_i[0];
        lch_pkg::CFG_COUNT_CONFUSION:  en_conf_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !busy && (!s1_vld_q || s1_adv);
  assign accept     = in_i.valid && in_i.ready;
  assign in_a_ok    = 32'(in_i.item.label_a) < 32'(NUM_LABELS);
  assign in_b_ok    = 32'(in_i.item.label_b) < 32'(NUM_LABELS);

  // A mismatch bin read sums both halves of the bin at label_a.
  assign rd_b = (in_i.item.operation == lch_pkg::OP_RD_MISM) ?
                IDX_W'(in_i.item.label_a) : IDX_W'(in_i.item.label_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (accept) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= in_i.item.operation;
      s1_a_q    <= IDX_W'(in_i.item.label_a);
      s1_b_q    <= IDX_W'(in_i.item.label_b);
      s1_a_ok_q <= in_a_ok;
      s1_b_ok_q <= in_b_ok;
      s1_diff_q <= in_i.item.label_a != in_i.item.label_b;
    end
  end

  lch_store #(
    .IDX_W       (IDX_W),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_o    (busy),
    .rd_en_i   (accept),
    .rd_a_i    (IDX_W'(in_i.item.label_a)),
    .rd_b_i    (rd_b),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_a_i    (s1_a_q),
    .wr_b_i    (s1_b_q),
    .wr_data_i (wr_data)
  );

  assign mism_sum = {1'b0, rd_data[lch_pkg::ST_MISM_A]} + {1'b0, rd_data[lch_pkg::ST_MISM_B]};
  assign mism_sat = mism_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : mism_sum[COUNT_WIDTH-1:0];

  always_comb begin
    wr_en_c        = '0;
    res_vld        = 1'b0;
    res_item       = '0;
    seq_frames_d   = seq_frames_q;
    seq_mism_d     = seq_mism_q;
    grand_frames_d = grand_frames_q;
    grand_mism_d   = grand_mism_q;
    for (int k = 0; k < lch_pkg::NUM_STORES; k++) begin
      wr_data[k] = sat_inc(rd_data[k]);
    end
    case (s1_op_q)
      lch_pkg::OP_PAIR: begin
        res_vld              = 1'b1;
        res_item.is_mismatch = s1_diff_q;
        seq_frames_d         = sat_inc(seq_frames_q);
        if (s1_diff_q) begin
          seq_mism_d = sat_inc(seq_mism_q);
        end
        wr_en_c.total  = en_totals_q && s1_a_ok_q;
        wr_en_c.mism_a = en_mism_q && s1_diff_q && s1_a_ok_q;
        wr_en_c.mism_b = en_mism_q && s1_diff_q && s1_b_ok_q;
        wr_en_c.conf   = en_conf_q && s1_a_ok_q && s1_b_ok_q;
      end
      lch_pkg::OP_END: begin
        res_vld             = 1'b1;
        res_item.frames     = lch_pkg::clip_grand(64'(seq_frames_q));
        res_item.mismatches = lch_pkg::clip_grand(64'(seq_mism_q));
        grand_frames_d      = lch_pkg::sat_add_grand(grand_frames_q, 64'(seq_frames_q));
        grand_mism_d        = lch_pkg::sat_add_grand(grand_mism_q, 64'(seq_mism_q));
        seq_frames_d        = '0;
        seq_mism_d          = '0;
      end
      lch_pkg::OP_RD_TOTAL: begin
        res_vld = 1'b1;
        if (s1_a_ok_q) begin
          res_item.entry_value = lch_pkg::clip_entry(64'(rd_data[lch_pkg::ST_TOTAL]));
        end
      end
      lch_pkg::OP_RD_MISM: begin
        res_vld = 1'b1;
        if (s1_a_ok_q) begin
          res_item.entry_value = lch_pkg::clip_entry(64'(mism_sat));
        end
      end
      lch_pkg::OP_RD_CONF: begin
        res_vld = 1'b1;
        if (s1_a_ok_q && s1_b_ok_q) begin
          res_item.entry_value = lch_pkg::clip_entry(64'(rd_data[lch_pkg::ST_CONF]));
        end
      end
      lch_pkg::OP_RD_GRAND: begin
        res_vld             = 1'b1;
        res_item.frames     = grand_frames_q;
        res_item.mismatches = grand_mism_q;
      end
      default: ;
    endcase
  end

  assign wr_en = s1_adv ? wr_en_c : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_frames_q   <= '0;
      seq_mism_q     <= '0;
      grand_frames_q <= '0;
      grand_mism_q   <= '0;
    end else if (s1_adv) begin
      seq_frames_q   <= seq_frames_d;
      seq_mism_q     <= seq_mism_d;
      grand_frames_q <= grand_frames_d;
      grand_mism_q   <= grand_mism_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_vld) begin
      out_item_q <= res_item;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.item  = out_item_q;

  `LCH_ASSERT(a_seq_cleared_on_end,
              (s1_adv && s1_op_q == lch_pkg::OP_END) |=>
              (seq_frames_q == '0 && seq_mism_q == '0),
              "sequence counters not cleared after end")
  `LCH_ASSERT(a_mism_within_frames, seq_mism_q <= seq_frames_q,
              "sequence mismatches exceed frames")
  `LCH_ASSERT(a_grand_monotonic, 1'b1 |=> (grand_frames_q >= $past(grand_frames_q)),
              "grand frame total decreased")

endmodule

`default_nettype wire
